/* sv/bpt_pkg.sv */
package bpt_pkg;

    localparam int RAW_W    = 24;
    localparam int COEF_W   = 16;
    localparam int IDX_W    = 3;
    localparam int DT_W     = 25;
    localparam int TEMP1_W  = 19;
    localparam int TEMP_W   = 20;
    localparam int WIDE_W   = 40;
    localparam int OUT_W    = 32;
    localparam int PRESS_W  = 30;
    localparam int T_REF    = 2000;
    localparam int T_COLD   = 1500;

    localparam logic [IDX_W-1:0] IDX_C1 = 3'd0;
    localparam logic [IDX_W-1:0] IDX_C2 = 3'd1;
    localparam logic [IDX_W-1:0] IDX_C3 = 3'd2;
    localparam logic [IDX_W-1:0] IDX_C4 = 3'd3;
    localparam logic [IDX_W-1:0] IDX_C5 = 3'd4;
    localparam logic [IDX_W-1:0] IDX_C6 = 3'd5;

    typedef struct packed {
        logic [COEF_W-1:0] c1;
        logic [COEF_W-1:0] c2;
        logic [COEF_W-1:0] c3;
        logic [COEF_W-1:0] c4;
        logic [COEF_W-1:0] c5;
        logic [COEF_W-1:0] c6;
    } coeff_t;

    typedef struct packed {
        logic                     valid;
        logic                     bad;
        logic [RAW_W-1:0]         d1;
        logic signed [TEMP_W-1:0] temp;
        logic signed [WIDE_W-1:0] off;
        logic signed [WIDE_W-1:0] sens;
    } front_t;

endpackage

/* sv/baro_pressure_temp_compensation_core.sv */
// Second-order temperature compensation for a barometric sensor.
// Load the six calibration coefficients C1..C6 through the cfg channel
// (cfg_index 0..5, 16-bit cfg_data) while no item is in flight; other
// indexes are ignored. cfg_ready is always high.
// Each input item is a pair of raw 24-bit readings (pressure, temperature).
// Each item yields exactly one result item: the pressure in 0.01 mbar and
// the temperature in 0.01 C, both 32-bit signed. When either reading is
// zero, valid_res is low and both values are zero.
// The datapath is a nine-stage pipeline that sustains one item per cycle
// while the receiver keeps m_ready high. The stage count is set by the
// chain of products (dT products, squares, the split D1 x SENS product)
// with a register after each multiplier.
// When the receiver holds m_ready low with a result waiting, the whole
// pipeline holds and s_ready falls; nothing is lost or repeated.
// Reset (aresetn low at a clock edge) clears the coefficients to zero
// and empties the pipeline.
module baro_pressure_temp_compensation_core import bpt_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [COEF_W-1:0]       cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [RAW_W-1:0]        s_raw_pressure,
    input  logic [RAW_W-1:0]        s_raw_temperature,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [OUT_W-1:0] m_pressure,
    output logic signed [OUT_W-1:0] m_temperature,
    output logic                    m_valid_res
);

    coeff_t coeff;
    front_t front;
    logic   adv;

    assign cfg_ready = 1'b1;
    assign adv       = !m_valid || m_ready;
    assign s_ready   = adv;

    bpt_regfile u_regfile (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .coeff    (coeff)
    );

    bpt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (s_valid),
        .d1_in    (s_raw_pressure),
        .d2_in    (s_raw_temperature),
        .coeff    (coeff),
        .out      (front)
    );

    bpt_press u_press (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (adv),
        .in          (front),
        .out_valid   (m_valid),
        .pressure    (m_pressure),
        .temperature (m_temperature),
        .valid_res   (m_valid_res)
    );

    a_incomplete_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_valid_res |-> m_pressure == '0 && m_temperature == '0)
        else $error("incomplete conversion gave nonzero result");

    a_temp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_temperature[OUT_W-1:TEMP_W-1] == '0
                 || m_temperature[OUT_W-1:TEMP_W-1] == '1)
        else $error("temperature exceeds its datapath width");

    a_press_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_pressure[OUT_W-1:PRESS_W-1] == '0
                 || m_pressure[OUT_W-1:PRESS_W-1] == '1)
        else $error("pressure exceeds its datapath width");

endmodule

/* sv/bpt_regfile.sv */
module bpt_regfile import bpt_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_index,
    input  logic [COEF_W-1:0] wr_data,
    output coeff_t            coeff
);

    coeff_t coeff_reg;
    coeff_t coeff_next;

    always_comb begin
        coeff_next = coeff_reg;
        if (wr_en) begin
            unique case (wr_index)
                IDX_C1: coeff_next.c1 = wr_data;
                IDX_C2: coeff_next.c2 = wr_data;
                IDX_C3: coeff_next.c3 = wr_data;
                IDX_C4: coeff_next.c4 = wr_data;
                IDX_C5: coeff_next.c5 = wr_data;
                IDX_C6: coeff_next.c6 = wr_data;
                default: coeff_next = coeff_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_reg <= '0;
        end else begin
            coeff_reg <= coeff_next;
        end
    end

    assign coeff = coeff_reg;

endmodule

/* sv/bpt_front.sv */
module bpt_front import bpt_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [RAW_W-1:0] d1_in,
    input  logic [RAW_W-1:0] d2_in,
    input  coeff_t           coeff,
    output front_t           out
);

    // Valid bits for stages one to six.
    logic [5:0] v_reg;

    // Stage 1: dT.
    logic                     bad1_reg;
    logic [RAW_W-1:0]         d1_1_reg;
    logic signed [DT_W-1:0]   dt1_reg;
    logic signed [DT_W-1:0]   dt_next;

    // Stage 2: the four products of dT.
    logic                     bad2_reg;
    logic [RAW_W-1:0]         d1_2_reg;
    logic signed [41:0]       p_temp_reg, p_sens_reg, p_off_reg;
    logic signed [49:0]       p_dd_reg;
    logic signed [41:0]       p_temp_next, p_sens_next, p_off_next;
    logic signed [49:0]       p_dd_next;
    logic signed [16:0]       c3s, c4s, c6s;

    // Stage 3: first-order terms.
    logic                     bad3_reg, low3_reg, cold3_reg;
    logic [RAW_W-1:0]         d1_3_reg;
    logic signed [TEMP1_W-1:0] temp1_3_reg, f_reg, g_reg, t2_3_reg;
    logic signed [WIDE_W-1:0] sens1_3_reg, off1_3_reg;
    logic signed [41:0]       p_temp_sh, p_sens_sh, p_off_sh;
    logic signed [49:0]       p_dd_sh;
    logic signed [TEMP1_W-1:0] f_next, g_next, temp1_next, t2_next;
    logic signed [WIDE_W-1:0] c1_term, c2_term, sens1_next, off1_next;

    // Stage 4: squares.
    logic                     bad4_reg, low4_reg, cold4_reg;
    logic [RAW_W-1:0]         d1_4_reg;
    logic signed [TEMP1_W-1:0] temp1_4_reg, t2_4_reg;
    logic signed [WIDE_W-1:0] sens1_4_reg, off1_4_reg;
    logic signed [37:0]       sq_reg, sq2_reg;
    logic signed [37:0]       sq_next, sq2_next;

    // Stage 5: second-order corrections.
    logic                     bad5_reg;
    logic [RAW_W-1:0]         d1_5_reg;
    logic signed [TEMP_W-1:0] temp5_reg;
    logic signed [WIDE_W-1:0] sens1_5_reg, off1_5_reg, off2_reg, sens2_reg;
    logic signed [WIDE_W-1:0] sq_w, sq2_w, sq5, sq2_7, sq2_11;
    logic signed [WIDE_W-1:0] off2_next, sens2_next;
    logic signed [TEMP_W-1:0] temp5_next;

    // Stage 6: corrected offset and sensitivity.
    logic                     bad6_reg;
    logic [RAW_W-1:0]         d1_6_reg;
    logic signed [TEMP_W-1:0] temp6_reg;
    logic signed [WIDE_W-1:0] off6_reg, sens6_reg;

    assign dt_next = $signed({1'b0, d2_in}) - $signed({1'b0, coeff.c5, 8'b0});

    assign c3s         = $signed({1'b0, coeff.c3});
    assign c4s         = $signed({1'b0, coeff.c4});
    assign c6s         = $signed({1'b0, coeff.c6});
    assign p_temp_next = dt1_reg * c6s;
    assign p_sens_next = dt1_reg * c3s;
    assign p_off_next  = dt1_reg * c4s;
    assign p_dd_next   = dt1_reg * dt1_reg;

    assign p_temp_sh  = p_temp_reg >>> 23;
    assign p_sens_sh  = p_sens_reg >>> 8;
    assign p_off_sh   = p_off_reg >>> 7;
    assign p_dd_sh    = p_dd_reg >>> 31;
    assign f_next     = p_temp_sh[TEMP1_W-1:0];
    assign temp1_next = f_next + TEMP1_W'(T_REF);
    assign g_next     = f_next + TEMP1_W'(T_REF + T_COLD);
    assign t2_next    = p_dd_sh[TEMP1_W-1:0];
    assign c1_term    = {{(WIDE_W-31){1'b0}}, coeff.c1, 15'b0};
    assign c2_term    = {{(WIDE_W-32){1'b0}}, coeff.c2, 16'b0};
    assign sens1_next = c1_term + p_sens_sh[WIDE_W-1:0];
    assign off1_next  = c2_term + p_off_sh[WIDE_W-1:0];

    assign sq_next  = f_reg * f_reg;
    assign sq2_next = g_reg * g_reg;

    assign sq_w       = WIDE_W'(sq_reg);
    assign sq2_w      = WIDE_W'(sq2_reg);
    assign sq5        = sq_w + (sq_w <<< 2);
    assign sq2_7      = (sq2_w <<< 3) - sq2_w;
    assign sq2_11     = (sq2_w <<< 3) + (sq2_w <<< 1) + sq2_w;
    assign off2_next  = !low4_reg ? '0 :
                        (sq5 >>> 1) + (cold4_reg ? sq2_7 : WIDE_W'(0));
    assign sens2_next = !low4_reg ? '0 :
                        (sq5 >>> 2) + (cold4_reg ? (sq2_11 >>> 1) : WIDE_W'(0));
    assign temp5_next = low4_reg ? TEMP_W'(temp1_4_reg) - TEMP_W'(t2_4_reg)
                                 : TEMP_W'(temp1_4_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bad1_reg    <= (d1_in == '0) || (d2_in == '0);
            d1_1_reg    <= d1_in;
            dt1_reg     <= dt_next;

            bad2_reg    <= bad1_reg;
            d1_2_reg    <= d1_1_reg;
            p_temp_reg  <= p_temp_next;
            p_sens_reg  <= p_sens_next;
            p_off_reg   <= p_off_next;
            p_dd_reg    <= p_dd_next;

            bad3_reg    <= bad2_reg;
            d1_3_reg    <= d1_2_reg;
            temp1_3_reg <= temp1_next;
            f_reg       <= f_next;
            g_reg       <= g_next;
            t2_3_reg    <= t2_next;
            sens1_3_reg <= sens1_next;
            off1_3_reg  <= off1_next;
            low3_reg    <= f_next < TEMP1_W'(0);
            cold3_reg   <= f_next < TEMP1_W'(-(T_REF + T_COLD));

            bad4_reg    <= bad3_reg;
            d1_4_reg    <= d1_3_reg;
            temp1_4_reg <= temp1_3_reg;
            t2_4_reg    <= t2_3_reg;
            sens1_4_reg <= sens1_3_reg;
            off1_4_reg  <= off1_3_reg;
            low4_reg    <= low3_reg;
            cold4_reg   <= cold3_reg;
            sq_reg      <= sq_next;
            sq2_reg     <= sq2_next;

            bad5_reg    <= bad4_reg;
            d1_5_reg    <= d1_4_reg;
            temp5_reg   <= temp5_next;
            sens1_5_reg <= sens1_4_reg;
            off1_5_reg  <= off1_4_reg;
            off2_reg    <= off2_next;
            sens2_reg   <= sens2_next;

            bad6_reg    <= bad5_reg;
            d1_6_reg    <= d1_5_reg;
            temp6_reg   <= temp5_reg;
            off6_reg    <= off1_5_reg - off2_reg;
            sens6_reg   <= sens1_5_reg - sens2_reg;
        end
    end

    assign out.valid = v_reg[5];
    assign out.bad   = bad6_reg;
    assign out.d1    = d1_6_reg;
    assign out.temp  = temp6_reg;
    assign out.off   = off6_reg;
    assign out.sens  = sens6_reg;

endmodule

/* sv/bpt_press.sv */
module bpt_press import bpt_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  front_t                  in,
    output logic                    out_valid,
    output logic signed [OUT_W-1:0] pressure,
    output logic signed [OUT_W-1:0] temperature,
    output logic                    valid_res
);

    localparam int PH_W   = RAW_W + 1 + (WIDE_W - 20);
    localparam int PL_W   = RAW_W + 20;
    localparam int PROD_W = 66;
    localparam int X_W    = 44;
    localparam int Y_W    = 46;

    logic [2:0] v_reg;

    // Stage 7: partial products of D1 and SENS.
    logic                     bad7_reg;
    logic signed [TEMP_W-1:0] temp7_reg;
    logic signed [WIDE_W-1:0] off7_reg;
    logic signed [PH_W-1:0]   ph_reg;
    logic [PL_W-1:0]          pl_reg;
    logic signed [WIDE_W-21:0] sens_hi;
    logic signed [PH_W-1:0]   ph_next;
    logic [PL_W-1:0]          pl_next;

    // Stage 8: full product, shifted.
    logic                     bad8_reg;
    logic signed [TEMP_W-1:0] temp8_reg;
    logic signed [WIDE_W-1:0] off8_reg;
    logic signed [X_W-1:0]    x_reg;
    logic signed [PROD_W-1:0] prod_hi, prod_lo, prod, prod_sh;

    // Stage 9: output register.
    logic                     valid_res_reg;
    logic signed [OUT_W-1:0]  pressure_reg, temperature_reg;
    logic signed [Y_W-1:0]    y, y_sh;
    logic signed [PRESS_W-1:0] p_next;

    assign sens_hi = in.sens[WIDE_W-1:20];
    assign ph_next = $signed({1'b0, in.d1}) * sens_hi;
    assign pl_next = in.d1 * in.sens[19:0];

    assign prod_hi = PROD_W'(ph_reg) <<< 20;
    assign prod_lo = {{(PROD_W-PL_W){1'b0}}, pl_reg};
    assign prod    = prod_hi + prod_lo;
    assign prod_sh = prod >>> 21;

    assign y      = Y_W'(x_reg) - Y_W'(off8_reg);
    assign y_sh   = y >>> 15;
    assign p_next = y_sh[PRESS_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[1:0], in.valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bad7_reg        <= in.bad;
            temp7_reg       <= in.temp;
            off7_reg        <= in.off;
            ph_reg          <= ph_next;
            pl_reg          <= pl_next;

            bad8_reg        <= bad7_reg;
            temp8_reg       <= temp7_reg;
            off8_reg        <= off7_reg;
            x_reg           <= prod_sh[X_W-1:0];

            valid_res_reg   <= !bad8_reg;
            pressure_reg    <= bad8_reg ? '0 : OUT_W'(p_next);
            temperature_reg <= bad8_reg ? '0 : OUT_W'(temp8_reg);
        end
    end

    assign out_valid   = v_reg[2];
    assign pressure    = pressure_reg;
    assign temperature = temperature_reg;
    assign valid_res   = valid_res_reg;

endmodule
